// File: rtl/core/dfp_pkg.sv
`timescale 1ns / 1ps

package dfp_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SCALE   = 2'd0;
	localparam logic [1:0] REG_INVERSE = 2'd1;
	localparam logic [1:0] REG_START   = 2'd2;
	localparam logic [1:0] REG_WIDTH   = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ROW_WIDTH_W = 13;
	localparam int VAL_W = 48;

	// register reset values
	localparam logic [31:0] SCALE_RST = 32'h0001_0000;
	localparam logic [31:0] INVERSE_RST = 32'h0001_0000;
	localparam logic [31:0] START_RST = 32'h0000_0000;
	localparam logic [ROW_WIDTH_W-1:0] WIDTH_RST = 13'd4096;

	// code for zero difference, and 127.5 in Q32
	localparam logic signed [15:0] CODE_ZERO = 16'sd127;
	localparam logic signed [54:0] HALF_BIAS_Q32 = 55'sh7F_8000_0000;
	localparam logic signed [15:0] CODE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] CODE_MIN = 16'sh8000;

	// position status from the row tracker to the sequencer
	typedef struct packed {
		logic first_cell;
		logic col_zero;
		logic last;
	} pos_status_t;

endpackage

// File: rtl/core/dfp_if.sv
`timescale 1ns / 1ps

// sample channel
interface dfp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               grid_start;

	modport source (output valid, output sample_value, output grid_start, input ready);
	modport sink   (input valid, input sample_value, input grid_start, output ready);
endinterface

// code channel
interface dfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       row_end;

	modport source (output valid, output code_byte, output row_end, input ready);
	modport sink   (input valid, input code_byte, input row_end, output ready);
endinterface

// File: rtl/core/dfp_mul.sv
`timescale 1ns / 1ps

module dfp_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);
	import dfp_pkg::*;

	// shared unsigned multiplier, product registered
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// File: rtl/core/dfp_pos.sv
`timescale 1ns / 1ps

module dfp_pos #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dfp_pkg::ROW_WIDTH_W-1:0]     row_width,
	input  logic                                grid_start,
	input  logic                                step,
	output dfp_pkg::pos_status_t                status
);
	import dfp_pkg::*;

	localparam int IDX_W = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int CMP_W = (IDX_W + 1 > ROW_WIDTH_W) ? IDX_W + 1 : ROW_WIDTH_W;
	localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_WIDTH);

	logic [IDX_W-1:0] col_q;
	logic             first_row_q;
	logic [IDX_W-1:0] eff_col;
	logic [CMP_W-1:0] rw_ext;
	logic [CMP_W-1:0] rw_clamp;
	logic [CMP_W-1:0] col_next;
	logic             first_cell;
	logic             last;

	// clamp row width to 1..MAX_ROW_WIDTH
	always_comb begin
		rw_ext = CMP_W'(row_width);
		if (rw_ext == '0)
			rw_clamp = CMP_W'(1);
		else if (rw_ext > MAX_W)
			rw_clamp = MAX_W;
		else
			rw_clamp = rw_ext;
	end

	// a grid restarts on a start mark or at column 0 of the first row
	always_comb begin
		first_cell = grid_start || (first_row_q && (col_q == '0));
		eff_col = first_cell ? '0 : col_q;
		col_next = CMP_W'(eff_col) + CMP_W'(1);
		last = (col_next >= rw_clamp);
	end

	assign status.first_cell = first_cell;
	assign status.col_zero = (col_q == '0);
	assign status.last = last;

	// column and first row tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_row_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				col_q <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_next[IDX_W-1:0];
				first_row_q <= first_cell ? 1'b1 : first_row_q;
			end
		end
	end

endmodule

// File: rtl/core/differential_feedback_packer.sv
`timescale 1ns / 1ps

// channel   modport  payload                       handshake
// samples   sink     sample_value[31:0], grid_start  valid/ready
// codes     source   code_byte[7:0], row_end         valid/ready
// cfg       write    cfg_index[1:0], cfg_data[31:0]  cfg_we
//
// an item passes through the sequencer states in order (IDLE, DIFF and OUT only for the first cell of a grid):
// the shared 32x32 multiplier is used three times in sequence, twice for the
// scaled difference and once for the reconstruction step.
// reset clears the sequencer, position, reconstruction state, configuration registers and output valid.
// a result waits in the output register; the next sample is taken meanwhile,
// and a new result stalls in its last step until that register is free.

module differential_feedback_packer #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dfp_in_if.sink                               samples,
	dfp_out_if.source                            codes,
	input  logic                                 cfg_we,
	input  logic [dfp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dfp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dfp_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_MLO  = 4'd2;
	localparam logic [3:0] ST_MHI  = 4'd3;
	localparam logic [3:0] ST_SUM  = 4'd4;
	localparam logic [3:0] ST_CODE = 4'd5;
	localparam logic [3:0] ST_STEP = 4'd6;
	localparam logic [3:0] ST_MUL2 = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q;

	logic [31:0]            scale_q;
	logic [31:0]            inverse_q;
	logic [31:0]            start_q;
	logic [ROW_WIDTH_W-1:0] width_q;

	logic signed [31:0]      sample_q;
	logic                    gstart_q;
	logic signed [VAL_W-1:0] pred_q;
	logic signed [VAL_W-1:0] row_head_q;
	logic signed [VAL_W-1:0] running_q;
	logic [48:0]             mag_q;
	logic                    neg_q;
	logic [31:0]             lohi_q;
	logic [31:0]             frac_q;
	logic [51:0]             t_q;
	logic                    sat_q;
	logic signed [15:0]      code_q;
	logic [15:0]             dmag_q;
	logic                    dneg_q;
	logic [7:0]              code_byte_q;
	logic                    row_end_q;
	logic                    out_valid_q;

	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          mul_p;
	pos_status_t          pos;
	logic                 slot_free;
	logic                 out_load;

	logic signed [VAL_W-1:0] pred_c;
	logic signed [48:0]      diff_c;
	logic [49:0]             q_c;
	logic signed [54:0]      x_c;
	logic signed [54:0]      xr_c;
	logic signed [22:0]      cf_c;
	logic signed [15:0]      code_c;
	logic signed [16:0]      d_c;
	logic [16:0]             dmag_c;
	logic signed [49:0]      step_c;
	logic signed [49:0]      sum_c;
	logic signed [VAL_W-1:0] upd_c;
	logic signed [VAL_W-1:0] start_ext;

	assign start_ext = VAL_W'($signed(start_q));
	assign slot_free = !out_valid_q || codes.ready;
	assign out_load = (state_q == ST_OUT) && slot_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			inverse_q <= INVERSE_RST;
			start_q <= START_RST;
			width_q <= WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE:   scale_q <= cfg_data;
				REG_INVERSE: inverse_q <= cfg_data;
				REG_START:   start_q <= cfg_data;
				REG_WIDTH:   width_q <= cfg_data[ROW_WIDTH_W-1:0];
				default:     ;
			endcase
		end
	end

	// row position tracker
	dfp_pos #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (width_q),
		.grid_start(gstart_q),
		.step      (out_load),
		.status    (pos)
	);

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MLO: begin
				mul_a = mag_q[31:0];
				mul_b = scale_q;
			end
			ST_MHI: begin
				mul_a = 32'(mag_q[48:32]);
				mul_b = scale_q;
			end
			ST_MUL2: begin
				mul_a = 32'(dmag_q);
				mul_b = inverse_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dfp_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(mul_p)
	);

	// difference against the prediction
	always_comb begin
		pred_c = pos.col_zero ? row_head_q : running_q;
		diff_c = 49'(sample_q) - 49'(pred_c);
	end

	// integer part of the scaled magnitude
	assign q_c = mul_p[49:0] + 50'(lohi_q);

	// signed scaled value plus 127.5, truncated toward zero, saturated
	always_comb begin
		x_c = (neg_q ? -$signed(55'(t_q)) : $signed(55'(t_q))) + HALF_BIAS_Q32;
		xr_c = x_c[54] ? x_c + 55'sh0_FFFF_FFFF : x_c;
		cf_c = xr_c[54:32];
		if (sat_q)
			code_c = neg_q ? CODE_MIN : CODE_MAX;
		else if (cf_c > 23'(CODE_MAX))
			code_c = CODE_MAX;
		else if (cf_c < 23'(CODE_MIN))
			code_c = CODE_MIN;
		else
			code_c = cf_c[15:0];
	end

	// code minus 127, as sign and magnitude
	always_comb begin
		d_c = 17'(code_q) - 17'(CODE_ZERO);
		dmag_c = d_c[16] ? 17'(-d_c) : 17'(d_c);
	end

	// reconstruction step with saturation to 48 bits
	always_comb begin
		step_c = $signed({2'b00, mul_p[47:0]});
		sum_c = 50'(pred_q) + (dneg_q ? -step_c : step_c);
		if (sum_c[49] != sum_c[47] || sum_c[48] != sum_c[47])
			upd_c = sum_c[49] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			upd_c = sum_c[VAL_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_head_q <= '0;
			running_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (samples.valid) state_q <= ST_DIFF;
				ST_DIFF: begin
					if (pos.first_cell) begin
						row_head_q <= start_ext;
						running_q <= start_ext;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MLO;
					end
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CODE;
				ST_CODE: state_q <= ST_STEP;
				ST_STEP: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_UPD;
				ST_UPD: begin
					running_q <= upd_c;
					if (pos.col_zero)
						row_head_q <= upd_c;
					state_q <= ST_OUT;
				end
				ST_OUT:  if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			sample_q <= samples.sample_value;
			gstart_q <= samples.grid_start;
		end
		if (state_q == ST_DIFF) begin
			pred_q <= pred_c;
			neg_q <= diff_c[48];
			mag_q <= diff_c[48] ? 49'(-diff_c) : 49'(diff_c);
			code_q <= CODE_ZERO;
		end
		if (state_q == ST_MHI) begin
			lohi_q <= mul_p[63:32];
			frac_q <= mul_p[31:0];
		end
		if (state_q == ST_SUM) begin
			sat_q <= |q_c[49:20];
			t_q <= {q_c[19:0], frac_q};
		end
		if (state_q == ST_CODE)
			code_q <= code_c;
		if (state_q == ST_STEP) begin
			dneg_q <= d_c[16];
			dmag_q <= dmag_c[15:0];
		end
		if (out_load) begin
			code_byte_q <= code_q[7:0];
			row_end_q <= pos.last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (codes.ready)
			out_valid_q <= 1'b0;
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign codes.valid = out_valid_q;
	assign codes.code_byte = code_byte_q;
	assign codes.row_end = row_end_q;

endmodule
